// ----- rtl/lps_pkg.sv -----
package lps_pkg;

	localparam int COORD_BITS = 12;
	localparam int ERR_BITS = COORD_BITS + 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_ADVANCE = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS:0] coord_ext_t;
	typedef logic [COORD_BITS-1:0] mag_t;
	typedef logic signed [ERR_BITS-1:0] err_t;

	typedef struct packed {
		logic func;
		coord_t first_x;
		coord_t first_y;
		coord_t second_x;
		coord_t second_y;
	} req_item_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		logic point_valid;
		logic is_last;
	} rsp_item_t;

	// Classified command passed from the front to the back through the queue
	typedef struct packed {
		logic is_start;
		coord_t begin_x;
		coord_t begin_y;
		coord_t end_major;
		logic steep;
		logic minor_negative;
		logic single_point;
		err_t error_init;
		err_t inc_axial;
		err_t inc_diag;
	} cmd_t;

endpackage

// ----- rtl/line_point_stepper.sv -----
// Bresenham line stepper: walks an integer line one point per beat.
// Request channel (req_valid / req_ready / req): func FUNC_START carries two
// endpoints and restarts the line; func FUNC_ADVANCE moves one step along it.
// Response channel (rsp_valid / rsp_ready / rsp): exactly one beat per request,
// in request order. point_valid drops to 0 once the line is finished, with
// the point and is_last cleared.
// A request accepted by the front passes through the setup stage, the command
// queue and the output register before its response beat can be taken.
// Throughput: one request per cycle when the receiver keeps up; each step
// is one add and compare in the back end's state loop.
// Reset clears the line state to a finished single point at the origin, so
// an advance before any start reports a finished line.
// When the receiver stalls, the output register holds its beat, the back end
// stops, the two-entry queue and then the setup stage fill, and req_ready
// then falls; nothing is lost.
module line_point_stepper (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  lps_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output lps_pkg::rsp_item_t rsp
);
	import lps_pkg::*;

	logic cmd_push_valid, cmd_push_ready;
	cmd_t cmd_push;
	logic cmd_pop_valid, cmd_pop_ready;
	cmd_t cmd_pop;

	// Front: classify the request and precompute the line setup
	lps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.cmd_valid(cmd_push_valid),
		.cmd_ready(cmd_push_ready),
		.cmd      (cmd_push)
	);

	// Queue: decouple the front from a stalled back end
	lps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(cmd_push_valid),
		.push_ready(cmd_push_ready),
		.push_data (cmd_push),
		.pop_valid (cmd_pop_valid),
		.pop_ready (cmd_pop_ready),
		.pop_data  (cmd_pop)
	);

	// Back: hold the line state, advance it and register the response
	lps_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_pop_valid),
		.cmd_ready(cmd_pop_ready),
		.cmd      (cmd_pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// A finished-line beat carries no point and no end flag
	a_finished_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.point_valid) |->
		(rsp.point_x == '0 && rsp.point_y == '0 && !rsp.is_last))
		else $error("finished-line beat carries data");

	// The front never stalls while the queue has room
	a_front_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_push_valid && cmd_push_ready) |-> req_ready)
		else $error("front stalled with room in the queue");

	// A command popped while the output is free always yields a response beat
	a_pop_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop_valid && cmd_pop_ready) |=> rsp_valid)
		else $error("command popped without a response beat");

endmodule

// ----- rtl/lps_front.sv -----
module lps_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  lps_pkg::req_item_t req,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output lps_pkg::cmd_t     cmd
);
	import lps_pkg::*;

	function automatic mag_t abs_diff(coord_t a, coord_t b);
		coord_ext_t ae;
		coord_ext_t be;
		coord_ext_t d;
		ae = coord_ext_t'(a);
		be = coord_ext_t'(b);
		d = (a > b) ? (ae - be) : (be - ae);
		return d[COORD_BITS-1:0];
	endfunction

	logic      valid_s1;
	req_item_t item_s1;
	mag_t      adx_s1, ady_s1;
	logic      gx_s1, lx_s1, gy_s1, ly_s1;

	logic   advance_s1;
	logic   steep;
	logic   first_is_end;
	logic   minor_neg;
	mag_t   maj, mnr;
	err_t   maj2, mnr2;

	assign advance_s1 = !valid_s1 || cmd_ready;
	assign req_ready  = advance_s1;

	// Stage 1: magnitudes and endpoint comparisons
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && req_valid) begin
			item_s1 <= req;
			adx_s1  <= abs_diff(req.first_x, req.second_x);
			ady_s1  <= abs_diff(req.first_y, req.second_y);
			gx_s1   <= req.first_x > req.second_x;
			lx_s1   <= req.first_x < req.second_x;
			gy_s1   <= req.first_y > req.second_y;
			ly_s1   <= req.first_y < req.second_y;
		end
	end

	// Stage 2: pick axes, order endpoints, form error terms
	always_comb begin
		steep        = ady_s1 > adx_s1;
		first_is_end = steep ? gy_s1 : gx_s1;
		minor_neg    = steep ? (gy_s1 ? lx_s1 : gx_s1) : (gx_s1 ? ly_s1 : gy_s1);
		maj          = steep ? ady_s1 : adx_s1;
		mnr          = steep ? adx_s1 : ady_s1;
		maj2         = err_t'({maj, 1'b0});
		mnr2         = err_t'({mnr, 1'b0});

		cmd.is_start       = item_s1.func == FUNC_START;
		cmd.begin_x        = first_is_end ? item_s1.second_x : item_s1.first_x;
		cmd.begin_y        = first_is_end ? item_s1.second_y : item_s1.first_y;
		cmd.end_major      = steep ? (first_is_end ? item_s1.first_y : item_s1.second_y)
		                           : (first_is_end ? item_s1.first_x : item_s1.second_x);
		cmd.steep          = steep;
		cmd.minor_negative = minor_neg;
		cmd.single_point   = maj == '0;
		cmd.error_init     = mnr2 - err_t'(maj);
		cmd.inc_axial      = mnr2;
		cmd.inc_diag       = mnr2 - maj2;
	end

	assign cmd_valid = valid_s1;

endmodule

// ----- rtl/lps_queue.sv -----
module lps_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  lps_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output lps_pkg::cmd_t pop_data
);
	import lps_pkg::*;

	function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	cmd_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push, pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

// ----- rtl/lps_back.sv -----
module lps_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  lps_pkg::cmd_t      cmd,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output lps_pkg::rsp_item_t rsp
);
	import lps_pkg::*;

	coord_t    cur_x_q, cur_y_q, end_major_q;
	logic      steep_q, minor_negative_q;
	err_t      error_q, inc_axial_q, inc_diag_q;
	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	logic   pop;
	coord_t major, minor, major_n, minor_n;
	logic   finished, take_diag;
	err_t   error_n;

	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign pop       = cmd_valid && cmd_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		major     = steep_q ? cur_y_q : cur_x_q;
		minor     = steep_q ? cur_x_q : cur_y_q;
		finished  = major == end_major_q;
		take_diag = error_q > 0;
		major_n   = major + coord_t'(1);
		if (!take_diag) minor_n = minor;
		else if (minor_negative_q) minor_n = minor - coord_t'(1);
		else minor_n = minor + coord_t'(1);
		error_n   = error_q + (take_diag ? inc_diag_q : inc_axial_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q          <= '0;
			cur_y_q          <= '0;
			end_major_q      <= '0;
			steep_q          <= 1'b0;
			minor_negative_q <= 1'b0;
			error_q          <= '0;
			inc_axial_q      <= '0;
			inc_diag_q       <= '0;
			rsp_valid_q      <= 1'b0;
		end else begin
			if (pop) begin
				rsp_valid_q <= 1'b1;
				if (cmd.is_start) begin
					cur_x_q          <= cmd.begin_x;
					cur_y_q          <= cmd.begin_y;
					end_major_q      <= cmd.end_major;
					steep_q          <= cmd.steep;
					minor_negative_q <= cmd.minor_negative;
					error_q          <= cmd.error_init;
					inc_axial_q      <= cmd.inc_axial;
					inc_diag_q       <= cmd.inc_diag;
				end else if (!finished) begin
					cur_x_q <= steep_q ? minor_n : major_n;
					cur_y_q <= steep_q ? major_n : minor_n;
					error_q <= error_n;
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cmd.is_start) begin
				rsp_q.point_x     <= cmd.begin_x;
				rsp_q.point_y     <= cmd.begin_y;
				rsp_q.point_valid <= 1'b1;
				rsp_q.is_last     <= cmd.single_point;
			end else if (!finished) begin
				rsp_q.point_x     <= steep_q ? minor_n : major_n;
				rsp_q.point_y     <= steep_q ? major_n : minor_n;
				rsp_q.point_valid <= 1'b1;
				rsp_q.is_last     <= major_n == end_major_q;
			end else begin
				rsp_q <= '0;
			end
		end
	end

endmodule
